[hdl/csc_pkg.sv]
// Package with shared widths, opcodes and unit result types for the conic chi-square scorer.
`timescale 1ns / 1ps
`default_nettype none
package csc_pkg;
  localparam int COEF_W = 40;
  localparam int POS_W  = 20;
  localparam int OPD_W  = 88;
  localparam int PROD_W = 2 * OPD_W;
  localparam int S_W    = 128;
  localparam int Q_W    = 48;
  localparam int SUM_W  = 48;
  localparam int CHI_W  = 40;
  localparam int FREE_PARAMS = 5;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_HIT   = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [CHI_W-1:0] CHI2_MAX = {CHI_W{1'b1}};

  typedef struct packed {
    logic              done;
    logic              neg;
    logic [PROD_W-1:0] prod;
  } mul_res_t;

  typedef struct packed {
    logic           done;
    logic           ovf;
    logic [Q_W-1:0] q;
  } div_res_t;
endpackage
`default_nettype wire

[hdl/csc_if.sv]
// Handshake interfaces for the hit input channel and the result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface csc_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic signed [csc_pkg::COEF_W-1:0] coef_a;
  logic signed [csc_pkg::COEF_W-1:0] coef_b;
  logic signed [csc_pkg::COEF_W-1:0] coef_c;
  logic signed [csc_pkg::COEF_W-1:0] coef_d;
  logic signed [csc_pkg::COEF_W-1:0] coef_e;
  logic signed [csc_pkg::COEF_W-1:0] coef_f;
  logic signed [csc_pkg::POS_W-1:0]  hit_x;
  logic signed [csc_pkg::POS_W-1:0]  hit_y;
  logic                              hit_present;
  modport source (output valid, op, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
                  hit_x, hit_y, hit_present, input ready);
  modport sink (input valid, op, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
                hit_x, hit_y, hit_present, output ready);
endinterface

interface csc_out_if;
  logic                       valid;
  logic                       ready;
  logic [csc_pkg::CHI_W-1:0]  chi2;
  logic                       chi2_valid;
  logic                       saturated;
  modport source (output valid, chi2, chi2_valid, saturated, input ready);
  modport sink (input valid, chi2, chi2_valid, saturated, output ready);
endinterface
`default_nettype wire

[hdl/conic_sampson_chi2_accumulator.sv]
// Top level of the conic Sampson-distance chi-square scorer.
// Ring-start beats, skipped hits, hits past the limit and unused opcodes return to idle
// straight from dispatch; a ring end with too few hits or an overflow goes to emit. A present hit
// runs fifteen products through the shared shift-add multiplier, then one quotient through
// the restoring divider, whose range check ends it early when the gradient is zero or the
// term overflows. A ring end with enough hits runs the divider once more. The block is not
// ready while it works; a finished result waits in the output register, and a ring end
// stalls until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module conic_sampson_chi2_accumulator #(
  parameter int MAX_HITS = 1024
) (
  input wire logic  clk,
  input wire logic  rst,
  csc_in_if.sink    hits,
  csc_out_if.source result
);
  localparam int CNT_W = $clog2(MAX_HITS + 1);
  localparam int OW = csc_pkg::OPD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT, S_END_WAIT, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    P_XX, P_XY, P_YY, P_AXX, P_BXY, P_CYY, P_DX, P_EY,
    P_AX, P_BY, P_BX, P_CY, P_GXX, P_GYY, P_RR
  } step_t;

  state_t state;
  step_t  step;

  logic [1:0] op;
  logic signed [csc_pkg::COEF_W-1:0] in_a, in_b, in_c, in_d, in_e, in_f;
  logic signed [csc_pkg::COEF_W-1:0] ka, kb, kc, kd, ke, kf;
  logic signed [csc_pkg::POS_W-1:0]  hx, hy;
  logic hp;

  logic [CNT_W-1:0]         hit_count;
  logic [csc_pkg::SUM_W-1:0] residual_sum;
  logic                      overflow_seen;

  logic signed [csc_pkg::COEF_W-1:0] xx, xy, yy;
  logic signed [OW-1:0] racc, gx, gy;
  logic [csc_pkg::S_W-1:0]    s;
  logic [csc_pkg::PROD_W-1:0] rr;

  logic                      out_valid;
  logic [csc_pkg::CHI_W-1:0] out_chi2;
  logic                      out_cv;
  logic                      out_sat;
  logic [csc_pkg::CHI_W-1:0] res_chi2;
  logic                      res_cv;
  logic                      res_sat;

  logic signed [OW-1:0] opa, opb, prod_s;
  logic mul_start, div_start, end_div;
  logic [csc_pkg::PROD_W-1:0] div_num;
  logic [csc_pkg::S_W-1:0]    div_den;
  logic [csc_pkg::SUM_W:0]    sum_next;
  csc_pkg::mul_res_t mres;
  csc_pkg::div_res_t dres;

  function automatic logic signed [OW-1:0] ext_c(input logic signed [csc_pkg::COEF_W-1:0] v);
    ext_c = {{(OW-csc_pkg::COEF_W){v[csc_pkg::COEF_W-1]}}, v};
  endfunction

  function automatic logic signed [OW-1:0] ext_p(input logic signed [csc_pkg::POS_W-1:0] v,
                                                 input int unsigned sh);
    ext_p = {{(OW-csc_pkg::POS_W){v[csc_pkg::POS_W-1]}}, v} <<< sh;
  endfunction

  always_comb begin
    case (step)
      P_XX:    begin opa = ext_p(hx, 0); opb = ext_p(hx, 0); end
      P_XY:    begin opa = ext_p(hx, 0); opb = ext_p(hy, 0); end
      P_YY:    begin opa = ext_p(hy, 0); opb = ext_p(hy, 0); end
      P_AXX:   begin opa = ext_c(ka); opb = ext_c(xx); end
      P_BXY:   begin opa = ext_c(kb); opb = ext_c(xy); end
      P_CYY:   begin opa = ext_c(kc); opb = ext_c(yy); end
      P_DX:    begin opa = ext_c(kd); opb = ext_p(hx, 8); end
      P_EY:    begin opa = ext_c(ke); opb = ext_p(hy, 8); end
      P_AX:    begin opa = ext_c(ka); opb = ext_p(hx, 1); end
      P_BY:    begin opa = ext_c(kb); opb = ext_p(hy, 0); end
      P_BX:    begin opa = ext_c(kb); opb = ext_p(hx, 0); end
      P_CY:    begin opa = ext_c(kc); opb = ext_p(hy, 1); end
      P_GXX:   begin opa = gx; opb = gx; end
      P_GYY:   begin opa = gy; opb = gy; end
      P_RR:    begin opa = racc; opb = racc; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign prod_s = mres.neg ? -mres.prod[OW-1:0] : mres.prod[OW-1:0];
  assign mul_start = (state == S_MUL_GO);

  assign end_div = (state == S_DISPATCH) && (op == csc_pkg::OP_END) &&
                   (hit_count > CNT_W'(csc_pkg::FREE_PARAMS)) && !overflow_seen;
  assign div_start = (state == S_DIV_GO) || end_div;
  assign div_num = (state == S_DIV_GO) ? rr :
                   csc_pkg::PROD_W'(residual_sum);
  assign div_den = (state == S_DIV_GO) ? s :
                   csc_pkg::S_W'(hit_count - CNT_W'(csc_pkg::FREE_PARAMS));
  assign sum_next = {1'b0, residual_sum} + {1'b0, dres.q};

  csc_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(opa), .b(opb), .res(mres)
  );

  csc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den), .res(dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= P_XX;
      ka <= '0; kb <= '0; kc <= '0; kd <= '0; ke <= '0; kf <= '0;
      hit_count     <= '0;
      residual_sum  <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (hits.valid) begin
            op   <= hits.op;
            in_a <= hits.coef_a; in_b <= hits.coef_b; in_c <= hits.coef_c;
            in_d <= hits.coef_d; in_e <= hits.coef_e; in_f <= hits.coef_f;
            hx   <= hits.hit_x;
            hy   <= hits.hit_y;
            hp   <= hits.hit_present;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (op)
            csc_pkg::OP_START: begin
              ka <= in_a; kb <= in_b; kc <= in_c; kd <= in_d; ke <= in_e; kf <= in_f;
              hit_count     <= '0;
              residual_sum  <= '0;
              overflow_seen <= 1'b0;
              state         <= S_IDLE;
            end
            csc_pkg::OP_HIT: begin
              if (hit_count < CNT_W'(MAX_HITS)) begin
                hit_count <= hit_count + CNT_W'(1);
              end
              if ((hit_count < CNT_W'(MAX_HITS)) && hp) begin
                racc  <= ext_c(kf) <<< 16;
                gx    <= ext_c(kd) <<< 8;
                gy    <= ext_c(ke) <<< 8;
                s     <= '0;
                step  <= P_XX;
                state <= S_MUL_GO;
              end else begin
                state <= S_IDLE;
              end
            end
            csc_pkg::OP_END: begin
              if (hit_count <= CNT_W'(csc_pkg::FREE_PARAMS)) begin
                res_chi2 <= '0; res_cv <= 1'b0; res_sat <= 1'b0;
                state    <= S_EMIT;
              end else if (overflow_seen) begin
                res_chi2 <= csc_pkg::CHI2_MAX; res_cv <= 1'b1; res_sat <= 1'b1;
                state    <= S_EMIT;
              end else begin
                state <= S_END_WAIT;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_MUL_GO: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mres.done) begin
            case (step)
              P_XX:  xx <= prod_s[csc_pkg::COEF_W-1:0];
              P_XY:  xy <= prod_s[csc_pkg::COEF_W-1:0];
              P_YY:  yy <= prod_s[csc_pkg::COEF_W-1:0];
              P_AXX, P_BXY, P_CYY, P_DX, P_EY: racc <= racc + prod_s;
              P_AX, P_BY: gx <= gx + prod_s;
              P_BX, P_CY: gy <= gy + prod_s;
              P_GXX, P_GYY: s <= s + mres.prod[csc_pkg::S_W-1:0];
              P_RR:  rr <= mres.prod;
              default: ;
            endcase
            if (step == P_RR) begin
              state <= S_DIV_GO;
            end else begin
              step  <= step_t'(step + 4'd1);
              state <= S_MUL_GO;
            end
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (dres.done) begin
            if (dres.ovf) begin
              overflow_seen <= 1'b1;
            end else if (sum_next[csc_pkg::SUM_W]) begin
              residual_sum  <= csc_pkg::SUM_MAX;
              overflow_seen <= 1'b1;
            end else begin
              residual_sum <= sum_next[csc_pkg::SUM_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        S_END_WAIT: begin
          if (dres.done) begin
            res_cv <= 1'b1;
            if (dres.q > csc_pkg::Q_W'(csc_pkg::CHI2_MAX)) begin
              res_chi2 <= csc_pkg::CHI2_MAX; res_sat <= 1'b1;
            end else begin
              res_chi2 <= dres.q[csc_pkg::CHI_W-1:0]; res_sat <= 1'b0;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid     <= 1'b1;
            out_chi2      <= res_chi2;
            out_cv        <= res_cv;
            out_sat       <= res_sat;
            hit_count     <= '0;
            residual_sum  <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign hits.ready        = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.chi2       = out_chi2;
  assign result.chi2_valid = out_cv;
  assign result.saturated  = out_sat;
endmodule
`default_nettype wire

[hdl/csc_mul.sv]
// Sequential shift-add multiplier on signed operands, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module csc_mul (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [csc_pkg::OPD_W-1:0]  a,
  input  wire logic signed [csc_pkg::OPD_W-1:0]  b,
  output csc_pkg::mul_res_t                      res
);
  localparam int CW = $clog2(csc_pkg::OPD_W + 1);

  logic [csc_pkg::PROD_W-1:0] mcand;
  logic [csc_pkg::OPD_W-1:0]  mplier;
  logic [csc_pkg::PROD_W-1:0] prod;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic                       done;
  logic                       neg;
  logic [csc_pkg::OPD_W-1:0]  mag_a;
  logic [csc_pkg::OPD_W-1:0]  mag_b;

  assign mag_a = a[csc_pkg::OPD_W-1] ? -a : a;
  assign mag_b = b[csc_pkg::OPD_W-1] ? -b : b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        mcand  <= {{csc_pkg::OPD_W{1'b0}}, mag_a};
        mplier <= mag_b;
        prod   <= '0;
        cnt    <= CW'(csc_pkg::OPD_W);
        neg    <= a[csc_pkg::OPD_W-1] ^ b[csc_pkg::OPD_W-1];
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res.done = done;
  assign res.neg  = neg;
  assign res.prod = prod;
endmodule
`default_nettype wire

[hdl/csc_div.sv]
// Restoring divider with a range check, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module csc_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [csc_pkg::PROD_W-1:0]   num,
  input  wire logic [csc_pkg::S_W-1:0]      den,
  output csc_pkg::div_res_t                 res
);
  localparam int CW = $clog2(csc_pkg::Q_W + 1);

  logic [csc_pkg::PROD_W-1:0] rem;
  logic [csc_pkg::PROD_W-1:0] dsh;
  logic [csc_pkg::Q_W-1:0]    q;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic                       done;
  logic                       ovf;
  logic [csc_pkg::PROD_W-1:0] limit;

  assign limit = {den, {csc_pkg::Q_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= start ? (num >= limit) : (busy && (cnt == CW'(1)));
      if (start) begin
        rem  <= num;
        dsh  <= {1'b0, den, {(csc_pkg::Q_W-1){1'b0}}};
        q    <= '0;
        cnt  <= CW'(csc_pkg::Q_W);
        ovf  <= (num >= limit);
        busy <= (num < limit);
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[csc_pkg::Q_W-2:0], 1'b1};
        end else begin
          q   <= {q[csc_pkg::Q_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.q    = q;
endmodule
`default_nettype wire

[hdl/csc_checker.sv]
// Port-level assertions for the conic chi-square scorer and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module csc_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [csc_pkg::CHI_W-1:0] chi2,
  input wire logic                      chi2_valid,
  input wire logic                      saturated
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chi2) && $stable(saturated))
    else $error("Stalled result beat changed.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chi2_valid |-> chi2 == '0 && !saturated)
    else $error("Invalid result carries a value.");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> chi2 == csc_pkg::CHI2_MAX && chi2_valid)
    else $error("Saturated result is not at maximum.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken on consecutive cycles.");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid right after reset.");
endmodule

bind conic_sampson_chi2_accumulator csc_checker u_csc_checker (
  .clk(clk), .rst(rst),
  .in_valid(hits.valid), .in_ready(hits.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .chi2(result.chi2), .chi2_valid(result.chi2_valid), .saturated(result.saturated)
);
`default_nettype wire
